[rtl/chc_pkg.sv]
// ----------------------------------------------------------------------------
// chc_pkg
// Shared widths, word limits and stage counts for the Hermite coefficient
// pipeline.
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // quotient bits resolved by the divider, one per stage
  localparam int unsigned QBITS         = DATA_W;
  // presat stage + one stage per quotient bit + round + saturate/sign
  localparam int unsigned DIV_STAGES    = QBITS + 3;
  localparam int unsigned FRONT_STAGES  = 4;
  localparam int unsigned PIPE_STAGES   = FRONT_STAGES + DIV_STAGES;

  localparam int unsigned IN_TDATA_W    = 5 * DATA_W;
  localparam int unsigned OUT_TDATA_W   = 4 * DATA_W;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    word_t coeff_linear;
    word_t coeff_constant;
  } side_t;

endpackage

[rtl/cubic_hermite_coefficients_top.sv]
// ----------------------------------------------------------------------------
// cubic_hermite_coefficients_top
// Cubic Hermite segment fit: coefficients a, b, c, d of d x^3 + c x^2 + b x + a
// from start/end value and slope and the segment width, all signed fixed point.
//
// Input request (in_tdata): start_value, start_slope, end_value, end_slope,
// segment_width, 32 bits each. Result request (out_tdata): coeff_constant,
// coeff_linear, coeff_square, coeff_cube; out_tuser flags a clipped c or d.
// Width zero or negative is fitted as width one with coeff_linear zero.
// Pipeline of 39 register stages: 4 front stages (products w^2, w^3 and the
// numerators) and 35 divider stages (presat, one per quotient bit for c and d
// in parallel, round, saturate). While out_tready stays high, one request per
// clock is taken and delivered, sustained.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up while the output stalls; in_tready falls only when all
// 39 stages hold requests and out_tready is low. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; no other state.
// ----------------------------------------------------------------------------
module cubic_hermite_coefficients_top #(
  parameter int unsigned FRAC_BITS = chc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_value, start_slope, end_value, end_slope, segment_width
  input  logic [chc_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // coeff_constant, coeff_linear, coeff_square, coeff_cube
  output logic [chc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // saturated
  output logic                              out_tuser
);
  import chc_pkg::*;

  localparam int unsigned W_W    = DATA_W - 1;
  localparam int unsigned DIFF_W = DATA_W + 1;
  localparam int unsigned TRI_W  = DIFF_W + 2;
  localparam int unsigned NDF_W  = DIFF_W + 1;
  localparam int unsigned SC_W   = DATA_W + 2;
  localparam int unsigned SD_W   = DATA_W + 1;
  localparam int unsigned PC_W   = SC_W + DATA_W;
  localparam int unsigned PD_W   = SD_W + DATA_W;
  localparam int unsigned W2_W   = 2 * W_W;
  localparam int unsigned W3_W   = 3 * W_W;
  localparam int unsigned MAGC_W = FRAC_BITS + 66;
  localparam int unsigned NC_W   = MAGC_W + 1;
  localparam int unsigned MAGD_W = 2 * FRAC_BITS + 64;
  localparam int unsigned ND_W   = MAGD_W + 1;
  localparam int unsigned N      = PIPE_STAGES;

  // pipeline control
  logic [N-1:0] v_r;
  logic [N-1:0] adv;
  side_t        side_r [N];
  side_t        side_nxt;

  // stage 0
  word_t                    y0, s0, y1, s1, wr;
  logic                     pos;
  logic [W_W-1:0]           w1_nxt, w1_r;
  logic signed [DIFF_W-1:0] dif_nxt, dif1_r;
  logic signed [SC_W-1:0]   sc_nxt, sc1_r;
  logic signed [SD_W-1:0]   sd_nxt, sd1_r;

  // stage 1
  logic [W2_W-1:0]          w2_nxt, w2_2_r;
  logic [W_W-1:0]           w_2_r;
  logic signed [PC_W-1:0]   pc_nxt, pc2_r;
  logic signed [PD_W-1:0]   pd_nxt, pd2_r;
  logic signed [TRI_W-1:0]  tri_nxt, tri2_r;
  logic signed [NDF_W-1:0]  ndf_nxt, ndf2_r;

  // stage 2
  logic [W2_W-1:0]          w3lo_nxt, w3lo3_r;
  logic [W2_W-1:0]          w3hi_nxt, w3hi3_r;
  logic [W2_W-1:0]          w2_3_r;
  logic signed [NC_W-1:0]   nc_nxt, nc3_r;
  logic signed [ND_W-1:0]   nd_nxt, nd3_r;

  // stage 3
  logic [W3_W-1:0]          w3_nxt, w3_4_r;
  logic [W2_W-1:0]          w2_4_r;
  logic [MAGC_W-1:0]        magc_nxt, magc4_r;
  logic [MAGD_W-1:0]        magd_nxt, magd4_r;
  logic                     negc4_r, negd4_r;

  // divider outputs
  word_t                    quo_c, quo_d;
  logic                     sat_c, sat_d;

  // ---------------- handshake / valid chain ----------------
  assign adv[N-1] = ~v_r[N-1] | out_tready;
  for (genvar i = 0; i < N - 1; i++) begin : g_adv
    assign adv[i] = ~v_r[i] | adv[i+1];
  end

  assign in_tready  = adv[0];
  assign out_tvalid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < N; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side_r[0] <= side_nxt;
    end
    for (int i = 1; i < N; i++) begin
      if (adv[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---------------- stage 0: unpack, sums ----------------
  assign y0 = word_t'(in_tdata[0*DATA_W +: DATA_W]);
  assign s0 = word_t'(in_tdata[1*DATA_W +: DATA_W]);
  assign y1 = word_t'(in_tdata[2*DATA_W +: DATA_W]);
  assign s1 = word_t'(in_tdata[3*DATA_W +: DATA_W]);
  assign wr = word_t'(in_tdata[4*DATA_W +: DATA_W]);

  assign pos     = ~wr[DATA_W-1] & (|wr);
  assign w1_nxt  = pos ? wr[W_W-1:0] : W_W'(1 << FRAC_BITS);
  assign dif_nxt = DIFF_W'(y1) - DIFF_W'(y0);
  assign sc_nxt  = SC_W'(s1) + (SC_W'(s0) <<< 1);
  assign sd_nxt  = SD_W'(s1) + SD_W'(s0);

  always_comb begin
    side_nxt.coeff_constant = y0;
    side_nxt.coeff_linear   = pos ? s0 : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      w1_r   <= w1_nxt;
      dif1_r <= dif_nxt;
      sc1_r  <= sc_nxt;
      sd1_r  <= sd_nxt;
    end
  end

  // ---------------- stage 1: w^2, slope products ----------------
  assign w2_nxt  = w1_r * w1_r;
  assign pc_nxt  = sc1_r * $signed({1'b0, w1_r});
  assign pd_nxt  = sd1_r * $signed({1'b0, w1_r});
  assign tri_nxt = (TRI_W'(dif1_r) <<< 1) + TRI_W'(dif1_r);
  assign ndf_nxt = -NDF_W'(dif1_r);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      w_2_r  <= w1_r;
      w2_2_r <= w2_nxt;
      pc2_r  <= pc_nxt;
      pd2_r  <= pd_nxt;
      tri2_r <= tri_nxt;
      ndf2_r <= ndf_nxt;
    end
  end

  // ---------------- stage 2: w^3 partials, numerators ----------------
  assign w3lo_nxt = w2_2_r[W_W-1:0] * w_2_r;
  assign w3hi_nxt = w2_2_r[W2_W-1:W_W] * w_2_r;
  assign nc_nxt   = (NC_W'(tri2_r) <<< (2 * FRAC_BITS)) - (NC_W'(pc2_r) <<< FRAC_BITS);
  assign nd_nxt   = (ND_W'(ndf2_r) <<< (3 * FRAC_BITS + 1))
                  + (ND_W'(pd2_r) <<< (2 * FRAC_BITS));

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      w2_3_r  <= w2_2_r;
      w3lo3_r <= w3lo_nxt;
      w3hi3_r <= w3hi_nxt;
      nc3_r   <= nc_nxt;
      nd3_r   <= nd_nxt;
    end
  end

  // ---------------- stage 3: w^3 sum, sign / magnitude ----------------
  assign w3_nxt   = (W3_W'(w3hi3_r) << W_W) + W3_W'(w3lo3_r);
  assign magc_nxt = nc3_r[NC_W-1] ? MAGC_W'(-nc3_r) : MAGC_W'(nc3_r);
  assign magd_nxt = nd3_r[ND_W-1] ? MAGD_W'(-nd3_r) : MAGD_W'(nd3_r);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      w2_4_r  <= w2_3_r;
      w3_4_r  <= w3_nxt;
      magc4_r <= magc_nxt;
      negc4_r <= nc3_r[NC_W-1];
      magd4_r <= magd_nxt;
      negd4_r <= nd3_r[ND_W-1];
    end
  end

  // ---------------- dividers: c = nc / w^2, d = nd / w^3 ----------------
  chc_rdiv #(
    .MAG_W (MAGC_W),
    .DEN_W (W2_W)
  ) u_div_c (
    .clk (clk),
    .adv (adv[N-1:FRONT_STAGES]),
    .mag (magc4_r),
    .den (w2_4_r),
    .neg (negc4_r),
    .quo (quo_c),
    .sat (sat_c)
  );

  chc_rdiv #(
    .MAG_W (MAGD_W),
    .DEN_W (W3_W)
  ) u_div_d (
    .clk (clk),
    .adv (adv[N-1:FRONT_STAGES]),
    .mag (magd4_r),
    .den (w3_4_r),
    .neg (negd4_r),
    .quo (quo_d),
    .sat (sat_d)
  );

  assign out_tdata = {quo_d, quo_c, side_r[N-1].coeff_linear, side_r[N-1].coeff_constant};
  assign out_tuser = sat_c | sat_d;

  // ---------------- assertions ----------------
  a_full_on_stall: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&v_r) && !out_tready))
    else $error("input stalled while pipeline has a free stage");

  a_sat_c_clip: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && sat_c) |-> (quo_c == WORD_MAX || quo_c == WORD_MIN))
    else $error("clipped coeff_square not at a range limit");

  a_sat_d_clip: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && sat_d) |-> (quo_d == WORD_MAX || quo_d == WORD_MIN))
    else $error("clipped coeff_cube not at a range limit");

  a_drain: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !v_r[N-2]) |=> !out_tvalid)
    else $error("result repeated after it was taken");

endmodule

[rtl/chc_rdiv.sv]
// ----------------------------------------------------------------------------
// chc_rdiv
// Pipelined restoring divider: magnitude / divisor, one quotient bit per
// stage, rounded half away from zero, sign applied and saturated to a word.
// ----------------------------------------------------------------------------
module chc_rdiv #(
  parameter int unsigned MAG_W = 82,
  parameter int unsigned DEN_W = 62
) (
  input  logic                             clk,
  input  logic [chc_pkg::DIV_STAGES-1:0]   adv,
  input  logic [MAG_W-1:0]                 mag,
  input  logic [DEN_W-1:0]                 den,
  input  logic                             neg,
  output chc_pkg::word_t                   quo,
  output logic                             sat
);
  import chc_pkg::*;

  localparam int unsigned CMP_W =
    ((MAG_W > DEN_W + QBITS) ? MAG_W : DEN_W + QBITS) + 1;
  localparam logic [QBITS:0] LIM_POS = {1'b0, WORD_MAX};
  localparam logic [QBITS:0] LIM_NEG = {1'b0, WORD_MIN};

  logic              presat_nxt;
  logic [MAG_W-1:0]  rem_r [QBITS+1];
  logic [DEN_W-1:0]  den_r [QBITS+1];
  logic [QBITS-1:0]  q_r   [QBITS+1];
  logic              neg_r [QBITS+2];
  logic              sat_r [QBITS+2];

  logic [CMP_W-1:0]  dsh   [1:QBITS];
  logic [CMP_W-1:0]  dif   [1:QBITS];
  logic              ge    [1:QBITS];

  logic [CMP_W-1:0]  rem2;
  logic              rnd_nxt;
  logic [QBITS:0]    qr_r;
  logic [QBITS:0]    qr_nxt;

  logic [QBITS:0]    lim;
  logic              over;
  word_t             quo_nxt;
  word_t             quo_r;
  logic              sato_r;

  // quotient of 2^QBITS or more can never fit
  assign presat_nxt = CMP_W'(mag) >= (CMP_W'(den) << QBITS);

  always_comb begin
    for (int j = 1; j <= QBITS; j++) begin
      dsh[j] = CMP_W'(den_r[j-1]) << (QBITS - j);
      dif[j] = CMP_W'(rem_r[j-1]) - dsh[j];
      ge[j]  = CMP_W'(rem_r[j-1]) >= dsh[j];
    end
  end

  assign rem2    = CMP_W'(rem_r[QBITS]) << 1;
  assign rnd_nxt = rem2 >= CMP_W'(den_r[QBITS]);
  assign qr_nxt  = {1'b0, q_r[QBITS]} + (QBITS+1)'(rnd_nxt);

  assign lim  = neg_r[QBITS+1] ? LIM_NEG : LIM_POS;
  assign over = sat_r[QBITS+1] | (qr_r > lim);

  always_comb begin
    if (over) begin
      quo_nxt = neg_r[QBITS+1] ? WORD_MIN : WORD_MAX;
    end else if (neg_r[QBITS+1]) begin
      quo_nxt = word_t'(QBITS'(0) - qr_r[QBITS-1:0]);
    end else begin
      quo_nxt = word_t'(qr_r[QBITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_r[0] <= mag;
      den_r[0] <= den;
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      sat_r[0] <= presat_nxt;
    end
    for (int j = 1; j <= QBITS; j++) begin
      if (adv[j]) begin
        rem_r[j] <= ge[j] ? dif[j][MAG_W-1:0] : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        q_r[j]   <= q_r[j-1] | (QBITS'(ge[j]) << (QBITS - j));
        neg_r[j] <= neg_r[j-1];
        sat_r[j] <= sat_r[j-1];
      end
    end
    if (adv[QBITS+1]) begin
      qr_r           <= qr_nxt;
      neg_r[QBITS+1] <= neg_r[QBITS];
      sat_r[QBITS+1] <= sat_r[QBITS];
    end
    if (adv[QBITS+2]) begin
      quo_r  <= quo_nxt;
      sato_r <= over;
    end
  end

  assign quo = quo_r;
  assign sat = sato_r;

endmodule
